>>> hw/rtl/aeske_pkg.sv
`timescale 1ns / 1ps
package aeske_pkg;
  localparam int WORD_W = 32;
  localparam int IDX_W = 6;
  localparam int WIN_DEPTH = 8;

  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EXPAND,
    ST_EMIT
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
endpackage

>>> hw/rtl/aes_key_expansion.sv
`timescale 1ns / 1ps
// A key word is echoed on the output in the cycle after it is taken. The Nk-th word
// then starts generation: each further schedule word takes four byte steps through
// one S-box and then an output step, plus any output stall; 44..60 words per schedule.
// Throughput: one item in flight; the single byte-wide S-box path sets the expansion rate.
// Reset: rst (synchronous) clears load count, Rcon to 0x01, length to 128-bit.
module aes_key_expansion
  import aeske_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // [1:0] key_length_select
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // [31:0] key_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // [31:0] round_key_word, [37:32] word_index
  output logic        m_tlast       // last_word
);
  state_t state, state_next;
  logic [1:0]  klen;
  logic [31:0] win [WIN_DEPTH];      // newest at 0; payload, no reset
  logic [5:0]  loaded;
  logic [7:0]  rcon;
  logic [5:0]  idx;                  // next generated index
  logic [3:0]  phase;                // idx mod Nk
  logic [1:0]  bcnt;                 // byte step in the S-box digit loop
  logic [31:0] tshift;               // temp word, shifted one byte per cycle
  logic        tsub;                 // this word passes bytes through the S-box
  logic [31:0] out_word;
  logic [5:0]  out_idx;
  logic        out_last;
  logic        out_full;

  logic [3:0] nk;
  logic [5:0] total;
  always_comb begin
    case (klen)
      KLEN_128: nk = 4'd4;
      KLEN_192: nk = 4'd6;
      default:  nk = 4'd8;
    endcase
    total = 6'({nk, 2'b00} + 6'd28);
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid = out_full;
  assign m_tdata = {2'b00, out_idx, out_word};
  assign m_tlast = out_last;

  logic accept_in;
  logic done_gen;
  logic out_load;
  assign accept_in = s_tvalid && s_tready;
  assign done_gen = (state == ST_EMIT) && (!out_full || m_tready);
  assign out_load = accept_in || done_gen;

  // In the load state, take a key word when the output slot is free or drains this cycle.
  always_comb begin
    s_tready = (state == ST_LOAD) && (!out_full || m_tready);
  end

  logic [5:0] loaded_inc;
  assign loaded_inc = loaded + 6'd1;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (accept_in && loaded_inc >= {2'b00, nk}) state_next = ST_EXPAND;
      ST_EXPAND: if (bcnt == 2'd3) state_next = ST_EMIT;
      ST_EMIT: begin
        if (done_gen) state_next = (idx == total - 6'd1) ? ST_LOAD : ST_EXPAND;
      end
      default:   state_next = ST_LOAD;
    endcase
  end

  logic [31:0] far_word;
  logic [7:0]  sb_in, sb_out;
  assign far_word = win[3'(nk - 4'd1)];
  assign sb_in = tshift[31:24];
  assign sb_out = tsub ? SBOX[sb_in] : sb_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      klen <= KLEN_128;
      loaded <= '0;
      rcon <= 8'h01;
      out_full <= 1'b0;
      bcnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) klen <= cfg_data[1:0];
      // Drop the held item once taken, unless a new one replaces it.
      if (out_full && m_tready && !out_load) out_full <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (accept_in) begin
            for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] <= win[k - 1];
            win[0] <= s_tdata;
            out_word <= s_tdata;
            out_idx <= loaded;
            out_last <= 1'b0;
            out_full <= 1'b1;
            loaded <= loaded_inc;
            idx <= {2'b00, nk};
            phase <= '0;
            bcnt <= '0;
            tshift <= {s_tdata[23:0], s_tdata[31:24]};
            tsub <= 1'b1;
          end
        end
        ST_EXPAND: begin
          // One byte per cycle through the S-box (bypassed when tsub is low), rotating into place.
          tshift <= {tshift[23:0], sb_out};
          bcnt <= bcnt + 2'd1;
        end
        ST_EMIT: begin
          if (done_gen) begin
            logic [31:0] w;
            w = far_word ^ tshift ^ ((phase == 4'd0) ? {rcon, 24'h0} : 32'h0);
            for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] <= win[k - 1];
            win[0] <= w;
            out_word <= w;
            out_idx <= idx;
            out_last <= (idx == total - 6'd1);
            out_full <= 1'b1;
            if (phase == 4'd0) rcon <= {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
            if (idx == total - 6'd1) begin
              loaded <= '0;
              rcon <= 8'h01;
            end
            idx <= idx + 6'd1;
            phase <= (phase == nk - 4'd1) ? 4'd0 : phase + 4'd1;
            bcnt <= '0;
            // Prime temp for the next word from the word being written now.
            if (((phase == nk - 4'd1) ? 4'd0 : phase + 4'd1) == 4'd0) begin
              tshift <= {w[23:0], w[31:24]};
              tsub <= 1'b1;
            end else begin
              tshift <= w;
              tsub <= (nk == 4'd8) && (phase + 4'd1 == 4'd4);
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hw/rtl/aes_key_expansion_checker.sv
`timescale 1ns / 1ps
module aes_key_expansion_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled item changed");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast && m_tdata[37:32] >= 6'd8 |-> !s_tready)
    else $error("input taken during expansion");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[37:32] == 6'd43 || m_tdata[37:32] == 6'd51
      || m_tdata[37:32] == 6'd59))
    else $error("last on wrong index");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:38] == 2'b00)
    else $error("pad bits set");
endmodule

bind aes_key_expansion aes_key_expansion_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
